FILE: hw/rtl/gpioexti_pkg.sv
// gpioexti_pkg: shared types, codes and helpers for the gpio port with
// external interrupt detection. no dependencies.
`timescale 1ns / 1ps

package gpioexti_pkg;

   localparam int DATA_W    = 8;
   localparam int ACTION_W  = 3;
   localparam int PORT_W    = 4;
   localparam int CSR_IDX_W = 3;
   localparam int SENSE_W   = 2;

   // control one comes out of reset as the port A value of the default family
   localparam logic [DATA_W-1:0] CTRL1_RESET = 8'h01;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PIN_DRIVE = 3'd0,
      ACT_OUT_DATA  = 3'd1,
      ACT_DIRECTION = 3'd2,
      ACT_CTRL_ONE  = 3'd3,
      ACT_CTRL_TWO  = 3'd4,
      ACT_STAT_ONE  = 3'd5,
      ACT_STAT_TWO  = 3'd6,
      ACT_RECHECK   = 3'd7
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PORT_INDEX  = 3'd0,
      CSR_FAMILY_S    = 3'd1,
      CSR_EXTI_ONE    = 3'd2,
      CSR_EXTI_TWO    = 3'd3,
      CSR_SENSE_ONE   = 3'd4,
      CSR_SENSE_TWO   = 3'd5,
      CSR_SENSE_THREE = 3'd6,
      CSR_SENSE_FOUR  = 3'd7
   } csr_idx_type;

   typedef enum logic [SENSE_W-1:0] {
      SENSE_LOW     = 2'd0,
      SENSE_RISING  = 2'd1,
      SENSE_FALLING = 2'd2,
      SENSE_BOTH    = 2'd3
   } sense_type;

   localparam logic [PORT_W-1:0] PORT_A = 4'd0;
   localparam logic [PORT_W-1:0] PORT_B = 4'd1;
   localparam logic [PORT_W-1:0] PORT_C = 4'd2;
   localparam logic [PORT_W-1:0] PORT_D = 4'd3;
   localparam logic [PORT_W-1:0] PORT_E = 4'd4;
   localparam logic [PORT_W-1:0] PORT_F = 4'd5;
   localparam logic [PORT_W-1:0] PORT_G = 4'd6;
   localparam logic [PORT_W-1:0] PORT_H = 4'd7;
   localparam logic [PORT_W-1:0] PORT_I = 4'd8;

   typedef struct packed {
      logic [PORT_W-1:0] port_index;
      logic              family_s;
      logic [DATA_W-1:0] exti_conf_one;
      logic [DATA_W-1:0] exti_conf_two;
      logic [DATA_W-1:0] sense_word_one;
      logic [DATA_W-1:0] sense_word_two;
      logic [DATA_W-1:0] sense_word_three;
      logic [DATA_W-1:0] sense_word_four;
   } cfg_type;

   // per-pin match for one sensitivity against the previous level
   function automatic logic [DATA_W-1:0] match_mask(sense_type sense,
                                                    logic [DATA_W-1:0] now,
                                                    logic [DATA_W-1:0] prev);
      logic [DATA_W-1:0] m;
      case (sense)
         SENSE_LOW:     m = ~now;
         SENSE_RISING:  m = ~prev & now;
         SENSE_FALLING: m = prev & ~now;
         default:       m = prev ^ now;
      endcase
      return m;
   endfunction

endpackage

FILE: hw/rtl/gpioexti_ifs.sv
// gpioexti_ifs: valid/ready channel interfaces for request, response and csr writes
// depends on gpioexti_pkg
`timescale 1ns / 1ps

interface gpioexti_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [gpioexti_pkg::ACTION_W-1:0]      action;
   logic [gpioexti_pkg::DATA_W-1:0]        value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface gpioexti_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [gpioexti_pkg::DATA_W-1:0]        pin_level;
   logic [gpioexti_pkg::DATA_W-1:0]        out_data;
   logic [gpioexti_pkg::DATA_W-1:0]        direction;
   logic [gpioexti_pkg::DATA_W-1:0]        control_one;
   logic [gpioexti_pkg::DATA_W-1:0]        control_two;
   logic [gpioexti_pkg::DATA_W-1:0]        status_one;
   logic [gpioexti_pkg::DATA_W-1:0]        status_two;
   logic                                   status_changed;

   modport source (output valid, output pin_level, output out_data, output direction,
                   output control_one, output control_two, output status_one,
                   output status_two, output status_changed, input ready);
   modport sink   (input valid, input pin_level, input out_data, input direction,
                   input control_one, input control_two, input status_one,
                   input status_two, input status_changed, output ready);
endinterface

interface gpioexti_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [gpioexti_pkg::CSR_IDX_W-1:0]     index;
   logic [gpioexti_pkg::DATA_W-1:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/gpioexti_detect.sv
// gpioexti_detect: whole-port and per-pin interrupt match, gives status bits to set
// depends on gpioexti_pkg
`timescale 1ns / 1ps

module gpioexti_detect (
   input  gpioexti_pkg::cfg_type                cfg,
   input  logic [gpioexti_pkg::DATA_W-1:0]      pin_now,
   input  logic [gpioexti_pkg::DATA_W-1:0]      pin_prev,
   input  logic [gpioexti_pkg::DATA_W-1:0]      enabled,
   output logic [gpioexti_pkg::DATA_W-1:0]      set_one,
   output logic [gpioexti_pkg::DATA_W-1:0]      set_two
);

   logic                                  port_lo;
   logic                                  port_hi;
   logic                                  in_use;
   gpioexti_pkg::sense_type               port_sense;
   logic [gpioexti_pkg::DATA_W-1:0]       port_match;
   logic                                  port_hit;
   logic [gpioexti_pkg::DATA_W-1:0]       flag_one;
   logic [gpioexti_pkg::DATA_W-1:0]       flag_two;
   logic [gpioexti_pkg::DATA_W-1:0]       pin_match;
   logic [2*gpioexti_pkg::DATA_W-1:0]     pin_senses;
   logic [gpioexti_pkg::DATA_W-1:0]       per_pin_mask;

   // whole-port versus per-pin selection, per nibble
   always_comb begin
      if (cfg.family_s) begin
         port_lo = 1'b1;
         port_hi = 1'b1;
      end else begin
         unique case (cfg.port_index)
            gpioexti_pkg::PORT_B: begin
               port_lo = cfg.exti_conf_one[0];
               port_hi = cfg.exti_conf_one[1];
            end
            gpioexti_pkg::PORT_D: begin
               port_lo = cfg.exti_conf_one[2];
               port_hi = cfg.exti_conf_one[3];
            end
            gpioexti_pkg::PORT_E: begin
               port_lo = cfg.exti_conf_one[4];
               port_hi = cfg.exti_conf_one[5];
            end
            gpioexti_pkg::PORT_F: begin
               port_lo = cfg.exti_conf_one[6];
               port_hi = cfg.exti_conf_two[0];
            end
            gpioexti_pkg::PORT_G: begin
               port_lo = cfg.exti_conf_two[1];
               port_hi = cfg.exti_conf_two[2];
            end
            gpioexti_pkg::PORT_H: begin
               port_lo = cfg.exti_conf_two[3];
               port_hi = cfg.exti_conf_two[4];
            end
            gpioexti_pkg::PORT_A, gpioexti_pkg::PORT_C, gpioexti_pkg::PORT_I: begin
               port_lo = 1'b0;
               port_hi = 1'b0;
            end
            default: begin
               port_lo = 1'b1;
               port_hi = 1'b1;
            end
         endcase
      end
   end

   // is the port routed to an interrupt line at all
   always_comb begin
      unique case (cfg.port_index)
         gpioexti_pkg::PORT_A, gpioexti_pkg::PORT_C: in_use = cfg.family_s;
         gpioexti_pkg::PORT_B: in_use = cfg.family_s | ~cfg.exti_conf_two[5];
         gpioexti_pkg::PORT_D: in_use = cfg.family_s | ~cfg.exti_conf_two[6];
         gpioexti_pkg::PORT_E: in_use = cfg.family_s | ~cfg.exti_conf_one[7];
         gpioexti_pkg::PORT_F: in_use = ~cfg.family_s & cfg.exti_conf_one[7];
         gpioexti_pkg::PORT_G: in_use = cfg.exti_conf_two[5];
         gpioexti_pkg::PORT_H: in_use = cfg.exti_conf_two[6];
         default:              in_use = 1'b0;
      endcase
   end

   // port sensitivity and flag position
   always_comb begin
      port_sense = gpioexti_pkg::SENSE_LOW;
      flag_one   = '0;
      flag_two   = '0;
      if (cfg.family_s) begin
         unique case (cfg.port_index)
            gpioexti_pkg::PORT_A:
               port_sense = gpioexti_pkg::sense_type'(cfg.sense_word_one[1:0]);
            gpioexti_pkg::PORT_B:
               port_sense = gpioexti_pkg::sense_type'(cfg.sense_word_one[3:2]);
            gpioexti_pkg::PORT_C:
               port_sense = gpioexti_pkg::sense_type'(cfg.sense_word_one[5:4]);
            gpioexti_pkg::PORT_D:
               port_sense = gpioexti_pkg::sense_type'(cfg.sense_word_one[7:6]);
            gpioexti_pkg::PORT_E:
               port_sense = gpioexti_pkg::sense_type'(cfg.sense_word_two[1:0]);
            default:
               port_sense = gpioexti_pkg::SENSE_LOW;
         endcase
         if (!cfg.port_index[gpioexti_pkg::PORT_W-1]) begin
            flag_one = gpioexti_pkg::DATA_W'(1) << cfg.port_index[2:0];
         end
      end else begin
         unique case (cfg.port_index)
            gpioexti_pkg::PORT_B: begin
               port_sense = gpioexti_pkg::sense_type'(cfg.sense_word_three[1:0]);
               flag_two   = 8'h01;
            end
            gpioexti_pkg::PORT_D: begin
               port_sense = gpioexti_pkg::sense_type'(cfg.sense_word_three[3:2]);
               flag_two   = 8'h02;
            end
            gpioexti_pkg::PORT_E: begin
               port_sense = gpioexti_pkg::sense_type'(cfg.sense_word_three[5:4]);
               flag_two   = 8'h04;
            end
            gpioexti_pkg::PORT_F: begin
               port_sense = gpioexti_pkg::sense_type'(cfg.sense_word_three[7:6]);
               flag_two   = 8'h08;
            end
            gpioexti_pkg::PORT_G:
               port_sense = gpioexti_pkg::sense_type'(cfg.sense_word_four[1:0]);
            gpioexti_pkg::PORT_H:
               port_sense = gpioexti_pkg::sense_type'(cfg.sense_word_four[3:2]);
            default:
               port_sense = gpioexti_pkg::SENSE_LOW;
         endcase
      end
   end

   assign port_match = gpioexti_pkg::match_mask(port_sense, pin_now, pin_prev) & enabled;
   assign port_hit   = in_use & ((port_hi & (|port_match[7:4])) |
                                 (port_lo & (|port_match[3:0])));

   // per-pin sensitivities: low nibble from word one, high nibble from word two
   assign pin_senses = {cfg.sense_word_two, cfg.sense_word_one};

   always_comb begin
      for (int i = 0; i < gpioexti_pkg::DATA_W; i++) begin
         pin_match[i] = |(gpioexti_pkg::match_mask(
                             gpioexti_pkg::sense_type'(pin_senses[2*i +: 2]),
                             pin_now, pin_prev) & (gpioexti_pkg::DATA_W'(1) << i));
      end
   end

   assign per_pin_mask = {{4{~port_hi}}, {4{~port_lo}}};

   assign set_one = (pin_match & enabled & per_pin_mask) | (port_hit ? flag_one : '0);
   assign set_two = port_hit ? flag_two : '0;

endmodule

FILE: hw/rtl/gpio_port_with_external_interrupts_unit.sv
// a transaction taken into the request register shows its result from the result register;
// one transaction per cycle while the response side is ready; the state update between
// them is combinational. csr writes are registered and take effect in the next cycle.
// reset (synchronous, active high): all port state and csr registers clear, control one
// loads 0x01, both channel stages empty.
// gpio port with external interrupts: top level, uses gpioexti_pkg, gpioexti_ifs,
// gpioexti_detect
`timescale 1ns / 1ps

module gpio_port_with_external_interrupts_unit (
   input  logic                  clock,
   input  logic                  reset,
   gpioexti_req_if.sink          req_bus,
   gpioexti_rsp_if.source        rsp_bus,
   gpioexti_csr_if.sink          csr_bus
);

   localparam int W = gpioexti_pkg::DATA_W;

   // csr registers
   gpioexti_pkg::cfg_type cfg_ff;
   gpioexti_pkg::cfg_type cfg_in;

   // request register
   logic                        req_valid_ff;
   gpioexti_pkg::action_type    req_action_ff;
   logic [W-1:0]                req_value_ff;
   logic                        req_take;
   logic                        req_fire;

   // port state
   logic [W-1:0] pin_state_ff, pin_state_in;
   logic [W-1:0] out_reg_ff, out_reg_in;
   logic [W-1:0] dir_reg_ff, dir_reg_in;
   logic [W-1:0] ctrl_one_ff, ctrl_one_in;
   logic [W-1:0] ctrl_two_ff, ctrl_two_in;
   logic [W-1:0] status_one_ff, status_one_in;
   logic [W-1:0] status_two_ff, status_two_in;
   logic [W-1:0] prev_input_ff;

   // after the register write, before detection
   logic [W-1:0] pins_wr;
   logic [W-1:0] stat_one_wr;
   logic [W-1:0] stat_two_wr;
   logic [W-1:0] enabled;
   logic [W-1:0] set_one;
   logic [W-1:0] set_two;
   logic         changed_in;

   // result register
   logic         rsp_valid_ff;
   logic [W-1:0] rsp_pin_ff, rsp_out_ff, rsp_dir_ff, rsp_ctrl_one_ff, rsp_ctrl_two_ff;
   logic [W-1:0] rsp_stat_one_ff, rsp_stat_two_ff;
   logic         rsp_changed_ff;

   // ---------------- csr port ----------------
   // always ready; users must write only while the port is idle; the block does not check
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (gpioexti_pkg::csr_idx_type'(csr_bus.index))
            gpioexti_pkg::CSR_PORT_INDEX:  cfg_in.port_index = csr_bus.data[3:0];
            gpioexti_pkg::CSR_FAMILY_S:    cfg_in.family_s = csr_bus.data[0];
            gpioexti_pkg::CSR_EXTI_ONE:    cfg_in.exti_conf_one = csr_bus.data;
            gpioexti_pkg::CSR_EXTI_TWO:    cfg_in.exti_conf_two = csr_bus.data;
            gpioexti_pkg::CSR_SENSE_ONE:   cfg_in.sense_word_one = csr_bus.data;
            gpioexti_pkg::CSR_SENSE_TWO:   cfg_in.sense_word_two = csr_bus.data;
            gpioexti_pkg::CSR_SENSE_THREE: cfg_in.sense_word_three = csr_bus.data;
            gpioexti_pkg::CSR_SENSE_FOUR:  cfg_in.sense_word_four = csr_bus.data;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- request register ----------------
   // the request stage moves on whenever the result register is free or being drained
   assign req_fire      = req_valid_ff & (~rsp_valid_ff | rsp_bus.ready);
   assign req_take      = req_bus.valid & req_bus.ready;
   assign req_bus.ready = ~req_valid_ff | req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         req_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_action_ff <= gpioexti_pkg::action_type'(req_bus.action);
         req_value_ff  <= req_bus.value;
      end
   end

   // ---------------- register write ----------------
   always_comb begin
      pins_wr     = pin_state_ff;
      out_reg_in  = out_reg_ff;
      dir_reg_in  = dir_reg_ff;
      ctrl_one_in = ctrl_one_ff;
      ctrl_two_in = ctrl_two_ff;
      stat_one_wr = status_one_ff;
      stat_two_wr = status_two_ff;
      unique case (req_action_ff)
         gpioexti_pkg::ACT_PIN_DRIVE: pins_wr     = req_value_ff;
         gpioexti_pkg::ACT_OUT_DATA:  out_reg_in  = req_value_ff;
         gpioexti_pkg::ACT_DIRECTION: dir_reg_in  = req_value_ff;
         gpioexti_pkg::ACT_CTRL_ONE:  ctrl_one_in = req_value_ff;
         gpioexti_pkg::ACT_CTRL_TWO:  ctrl_two_in = req_value_ff;
         gpioexti_pkg::ACT_STAT_ONE:  stat_one_wr = req_value_ff;
         gpioexti_pkg::ACT_STAT_TWO:  stat_two_wr = req_value_ff;
         default:                     pins_wr     = pin_state_ff;  // recheck
      endcase
   end

   // mixed level: pins where input, output data where output
   assign pin_state_in = (pins_wr & ~dir_reg_in) | (out_reg_in & dir_reg_in);
   assign enabled      = ~dir_reg_in & ctrl_two_in;

   // ---------------- interrupt detection ----------------
   gpioexti_detect u_detect (
      .cfg      (cfg_ff),
      .pin_now  (pin_state_in),
      .pin_prev (prev_input_ff),
      .enabled  (enabled),
      .set_one  (set_one),
      .set_two  (set_two)
   );

   assign status_one_in = stat_one_wr | set_one;
   assign status_two_in = stat_two_wr | set_two;
   // only bits not already present after the write count as new
   assign changed_in    = (|(set_one & ~stat_one_wr)) | (|(set_two & ~stat_two_wr));

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_state_ff  <= '0;
         out_reg_ff    <= '0;
         dir_reg_ff    <= '0;
         ctrl_one_ff   <= gpioexti_pkg::CTRL1_RESET;
         ctrl_two_ff   <= '0;
         status_one_ff <= '0;
         status_two_ff <= '0;
         prev_input_ff <= '0;
      end else if (req_fire) begin
         pin_state_ff  <= pin_state_in;
         out_reg_ff    <= out_reg_in;
         dir_reg_ff    <= dir_reg_in;
         ctrl_one_ff   <= ctrl_one_in;
         ctrl_two_ff   <= ctrl_two_in;
         status_one_ff <= status_one_in;
         status_two_ff <= status_two_in;
         prev_input_ff <= pin_state_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_pin_ff      <= pin_state_in;
         rsp_out_ff      <= out_reg_in;
         rsp_dir_ff      <= dir_reg_in;
         rsp_ctrl_one_ff <= ctrl_one_in;
         rsp_ctrl_two_ff <= ctrl_two_in;
         rsp_stat_one_ff <= status_one_in;
         rsp_stat_two_ff <= status_two_in;
         rsp_changed_ff  <= changed_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.pin_level      = rsp_pin_ff;
   assign rsp_bus.out_data       = rsp_out_ff;
   assign rsp_bus.direction      = rsp_dir_ff;
   assign rsp_bus.control_one    = rsp_ctrl_one_ff;
   assign rsp_bus.control_two    = rsp_ctrl_two_ff;
   assign rsp_bus.status_one     = rsp_stat_one_ff;
   assign rsp_bus.status_two     = rsp_stat_two_ff;
   assign rsp_bus.status_changed = rsp_changed_ff;

   // ---------------- assertions ----------------
`ifndef ASSERT_OFF
   // status one only loses bits through its own write
   a_status_sticky: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_action_ff != gpioexti_pkg::ACT_STAT_ONE) |=>
         ((status_one_ff & $past(status_one_ff)) == $past(status_one_ff)))
      else $error("status one bit cleared without a status write");

   // a reported change means some status bit is set
   a_changed_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_changed_ff) |-> ((rsp_stat_one_ff | rsp_stat_two_ff) != '0))
      else $error("status change flagged with empty status");

   // output-direction pins read back the output data
   a_output_readback: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (((rsp_pin_ff ^ rsp_out_ff) & rsp_dir_ff) == '0))
      else $error("pin level differs from output data on an output pin");

   // a held request is never overwritten
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !req_fire) |=> (req_valid_ff && $stable(req_value_ff)))
      else $error("pending request lost or overwritten");
`endif

endmodule

FILE: bench/gpio_port_with_external_interrupts_unit_test.sv
// testbench for the gpio port with external interrupt detection: predicts every
// response transaction from its own port model and checks it field by field
// depends on gpioexti_pkg, gpioexti_ifs and gpio_port_with_external_interrupts_unit
`timescale 1ns / 1ps

module gpio_port_with_external_interrupts_unit_test;

   localparam int DW = gpioexti_pkg::DATA_W;

   // one response transaction as the port model predicts it
   typedef struct {
      logic [DW-1:0] pin_level;
      logic [DW-1:0] out_data;
      logic [DW-1:0] direction;
      logic [DW-1:0] control_one;
      logic [DW-1:0] control_two;
      logic [DW-1:0] status_one;
      logic [DW-1:0] status_two;
      logic          status_changed;
   } port_view_type;

   logic clock;
   logic reset;

   gpioexti_req_if req_bus ();
   gpioexti_rsp_if rsp_bus ();
   gpioexti_csr_if csr_bus ();

   gpio_port_with_external_interrupts_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // port views still owed by the block, oldest first
   port_view_type pending_views[$];

   // model copy of the csr settings and the port registers
   gpioexti_pkg::cfg_type port_cfg;
   logic [DW-1:0] level_q, out_q, dir_q, ctl1_q, ctl2_q, stat1_q, stat2_q;
   logic [DW-1:0] prior_level;

   int mismatch_count;
   int sender_idle_pct;
   int receiver_stall_pct;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // generous ceiling, sized for the slowest phases
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // port model
   // ---------------------------------------------------------------------------

   // pins that match one sensitivity code against the previous level
   function automatic logic [DW-1:0] sense_hits(gpioexti_pkg::sense_type s,
                                                logic [DW-1:0] now,
                                                logic [DW-1:0] prev);
      case (s)
         gpioexti_pkg::SENSE_LOW:     return ~now;
         gpioexti_pkg::SENSE_RISING:  return ~prev & now;
         gpioexti_pkg::SENSE_FALLING: return prev & ~now;
         default:                     return prev ^ now;
      endcase
   endfunction

   // does this nibble take the whole-port check rather than per-pin checks
   function automatic bit nibble_whole_port(bit hi);
      logic [DW-1:0] c1, c2;
      c1 = port_cfg.exti_conf_one;
      c2 = port_cfg.exti_conf_two;
      if (port_cfg.family_s) return 1'b1;
      case (port_cfg.port_index)
         gpioexti_pkg::PORT_B: return hi ? c1[1] : c1[0];
         gpioexti_pkg::PORT_D: return hi ? c1[3] : c1[2];
         gpioexti_pkg::PORT_E: return hi ? c1[5] : c1[4];
         gpioexti_pkg::PORT_F: return hi ? c2[0] : c1[6];
         gpioexti_pkg::PORT_G: return hi ? c2[2] : c2[1];
         gpioexti_pkg::PORT_H: return hi ? c2[4] : c2[3];
         gpioexti_pkg::PORT_A, gpioexti_pkg::PORT_C, gpioexti_pkg::PORT_I: return 1'b0;
         // ports past I still take the whole-port path on the other family
         default:              return 1'b1;
      endcase
   endfunction

   // is this port routed to an interrupt line at all
   function automatic bit port_routed();
      bit fam;
      fam = port_cfg.family_s;
      case (port_cfg.port_index)
         gpioexti_pkg::PORT_A, gpioexti_pkg::PORT_C: return fam;
         gpioexti_pkg::PORT_B: return fam || !port_cfg.exti_conf_two[5];
         gpioexti_pkg::PORT_D: return fam || !port_cfg.exti_conf_two[6];
         gpioexti_pkg::PORT_E: return fam || !port_cfg.exti_conf_one[7];
         gpioexti_pkg::PORT_F: return !fam && port_cfg.exti_conf_one[7];
         gpioexti_pkg::PORT_G: return port_cfg.exti_conf_two[5];
         gpioexti_pkg::PORT_H: return port_cfg.exti_conf_two[6];
         default:              return 1'b0;
      endcase
   endfunction

   function automatic gpioexti_pkg::sense_type port_sense_code();
      if (port_cfg.family_s) begin
         case (port_cfg.port_index)
            gpioexti_pkg::PORT_A:
               return gpioexti_pkg::sense_type'(port_cfg.sense_word_one[1:0]);
            gpioexti_pkg::PORT_B:
               return gpioexti_pkg::sense_type'(port_cfg.sense_word_one[3:2]);
            gpioexti_pkg::PORT_C:
               return gpioexti_pkg::sense_type'(port_cfg.sense_word_one[5:4]);
            gpioexti_pkg::PORT_D:
               return gpioexti_pkg::sense_type'(port_cfg.sense_word_one[7:6]);
            gpioexti_pkg::PORT_E:
               return gpioexti_pkg::sense_type'(port_cfg.sense_word_two[1:0]);
            default:
               return gpioexti_pkg::SENSE_LOW;
         endcase
      end
      case (port_cfg.port_index)
         gpioexti_pkg::PORT_B:
            return gpioexti_pkg::sense_type'(port_cfg.sense_word_three[1:0]);
         gpioexti_pkg::PORT_D:
            return gpioexti_pkg::sense_type'(port_cfg.sense_word_three[3:2]);
         gpioexti_pkg::PORT_E:
            return gpioexti_pkg::sense_type'(port_cfg.sense_word_three[5:4]);
         gpioexti_pkg::PORT_F:
            return gpioexti_pkg::sense_type'(port_cfg.sense_word_three[7:6]);
         gpioexti_pkg::PORT_G:
            return gpioexti_pkg::sense_type'(port_cfg.sense_word_four[1:0]);
         gpioexti_pkg::PORT_H:
            return gpioexti_pkg::sense_type'(port_cfg.sense_word_four[3:2]);
         default:
            return gpioexti_pkg::SENSE_LOW;
      endcase
   endfunction

   // port flag lands in status one on the s family, status two otherwise
   function automatic void raise_port_flag();
      if (port_cfg.family_s) begin
         if (port_cfg.port_index < gpioexti_pkg::PORT_I)
            stat1_q[port_cfg.port_index[2:0]] = 1'b1;
      end else if (port_cfg.port_index == gpioexti_pkg::PORT_B) begin
         stat2_q[0] = 1'b1;
      end else if (port_cfg.port_index >= gpioexti_pkg::PORT_D &&
                   port_cfg.port_index <= gpioexti_pkg::PORT_F) begin
         stat2_q[int'(port_cfg.port_index) - int'(gpioexti_pkg::PORT_B) - 1] = 1'b1;
      end
   endfunction

   // apply one request transaction to the model and return the port view after it
   function automatic port_view_type apply_transaction(gpioexti_pkg::action_type act,
                                                       logic [DW-1:0] val);
      logic [DW-1:0] pins, s1_before, s2_before, enabled, nib_mask, hits, sense_byte;
      port_view_type view;
      pins = level_q;
      case (act)
         gpioexti_pkg::ACT_PIN_DRIVE: pins = val;
         gpioexti_pkg::ACT_OUT_DATA:  out_q = val;
         gpioexti_pkg::ACT_DIRECTION: dir_q = val;
         gpioexti_pkg::ACT_CTRL_ONE:  ctl1_q = val;
         gpioexti_pkg::ACT_CTRL_TWO:  ctl2_q = val;
         gpioexti_pkg::ACT_STAT_ONE:  stat1_q = val;
         gpioexti_pkg::ACT_STAT_TWO:  stat2_q = val;
         default:                     ;
      endcase
      // output pins read back their own data, and that mixed level is kept
      level_q = (pins & ~dir_q) | (out_q & dir_q);
      s1_before = stat1_q;
      s2_before = stat2_q;
      enabled = ~dir_q & ctl2_q;
      for (int h = 0; h < 2; h++) begin
         nib_mask = (h != 0) ? 8'hF0 : 8'h0F;
         if (nibble_whole_port(h != 0)) begin
            if (port_routed()) begin
               hits = sense_hits(port_sense_code(), level_q, prior_level);
               if ((hits & enabled & nib_mask) != '0) raise_port_flag();
            end
         end else begin
            sense_byte = (h != 0) ? port_cfg.sense_word_two : port_cfg.sense_word_one;
            for (int i = 0; i < 4; i++) begin
               hits = sense_hits(gpioexti_pkg::sense_type'(sense_byte[2*i +: 2]),
                                 level_q, prior_level);
               if (enabled[4*h + i] && hits[4*h + i]) stat1_q[4*h + i] = 1'b1;
            end
         end
      end
      prior_level = level_q;
      view.pin_level      = level_q;
      view.out_data       = out_q;
      view.direction      = dir_q;
      view.control_one    = ctl1_q;
      view.control_two    = ctl2_q;
      view.status_one     = stat1_q;
      view.status_two     = stat2_q;
      view.status_changed = (stat1_q != s1_before) || (stat2_q != s2_before);
      return view;
   endfunction

   function automatic void reset_model();
      port_cfg = '0;
      level_q = '0; out_q = '0; dir_q = '0; ctl2_q = '0;
      stat1_q = '0; stat2_q = '0; prior_level = '0;
      // control one reset follows the family and port in force at reset
      if (port_cfg.family_s)
         ctl1_q = (port_cfg.port_index == gpioexti_pkg::PORT_D) ? 8'h02 : 8'h00;
      else
         ctl1_q = (port_cfg.port_index == gpioexti_pkg::PORT_A) ? 8'h01 : 8'h00;
   endfunction

   function automatic logic [DW-1:0] csr_word(gpioexti_pkg::cfg_type c,
                                              gpioexti_pkg::csr_idx_type idx);
      case (idx)
         gpioexti_pkg::CSR_PORT_INDEX:
            return {{(DW-gpioexti_pkg::PORT_W){1'b0}}, c.port_index};
         gpioexti_pkg::CSR_FAMILY_S:    return {{(DW-1){1'b0}}, c.family_s};
         gpioexti_pkg::CSR_EXTI_ONE:    return c.exti_conf_one;
         gpioexti_pkg::CSR_EXTI_TWO:    return c.exti_conf_two;
         gpioexti_pkg::CSR_SENSE_ONE:   return c.sense_word_one;
         gpioexti_pkg::CSR_SENSE_TWO:   return c.sense_word_two;
         gpioexti_pkg::CSR_SENSE_THREE: return c.sense_word_three;
         default:                       return c.sense_word_four;
      endcase
   endfunction

   function automatic void apply_csr(gpioexti_pkg::csr_idx_type idx, logic [DW-1:0] d);
      case (idx)
         gpioexti_pkg::CSR_PORT_INDEX:  port_cfg.port_index = d[gpioexti_pkg::PORT_W-1:0];
         gpioexti_pkg::CSR_FAMILY_S:    port_cfg.family_s = d[0];
         gpioexti_pkg::CSR_EXTI_ONE:    port_cfg.exti_conf_one = d;
         gpioexti_pkg::CSR_EXTI_TWO:    port_cfg.exti_conf_two = d;
         gpioexti_pkg::CSR_SENSE_ONE:   port_cfg.sense_word_one = d;
         gpioexti_pkg::CSR_SENSE_TWO:   port_cfg.sense_word_two = d;
         gpioexti_pkg::CSR_SENSE_THREE: port_cfg.sense_word_three = d;
         default:                       port_cfg.sense_word_four = d;
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // response side: check accepted transactions, then pick next cycle's ready
   // ---------------------------------------------------------------------------

   task automatic compare_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s at %0t: expected %h, got %h", name, $realtime, want, got);
      end
   endtask

   always @(posedge clock) begin
      port_view_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_views.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("response transaction with nothing pending at %0t", $realtime);
         end else begin
            want = pending_views.pop_front();
            compare_field("pin_level", want.pin_level, rsp_bus.pin_level);
            compare_field("out_data", want.out_data, rsp_bus.out_data);
            compare_field("direction", want.direction, rsp_bus.direction);
            compare_field("control_one", want.control_one, rsp_bus.control_one);
            compare_field("control_two", want.control_two, rsp_bus.control_two);
            compare_field("status_one", want.status_one, rsp_bus.status_one);
            compare_field("status_two", want.status_two, rsp_bus.status_two);
            compare_field("status_changed", {7'b0, want.status_changed},
                          {7'b0, rsp_bus.status_changed});
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // valid stays high after the handshake so back-to-back transactions never
   // drop it; whoever stops sending lowers it through drain_port
   task automatic send_item(gpioexti_pkg::action_type act, logic [DW-1:0] val);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.value  <= val;
      do @(posedge clock); while (!req_bus.ready);
      pending_views.push_back(apply_transaction(act, val));
   endtask

   // stop sending and wait until every pending view has come back
   task automatic drain_port();
      req_bus.valid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      // two-stage pipe, a little margin past it
      repeat (4) @(posedge clock);
   endtask

   // write all csr registers back to back, only ever called while drained
   task automatic program_port(gpioexti_pkg::cfg_type c);
      gpioexti_pkg::csr_idx_type idx;
      idx = idx.first();
      csr_bus.valid <= 1'b1;
      repeat (idx.num()) begin
         csr_bus.index <= idx;
         csr_bus.data  <= csr_word(c, idx);
         do @(posedge clock); while (!csr_bus.ready);
         apply_csr(idx, csr_word(c, idx));
         idx = idx.next();
      end
      csr_bus.valid <= 1'b0;
   endtask

   function automatic gpioexti_pkg::cfg_type random_setting();
      gpioexti_pkg::cfg_type c;
      // mostly real ports, now and then an index past port I
      c.port_index       = ($urandom_range(9) == 0)
                           ? gpioexti_pkg::PORT_W'($urandom_range(15))
                           : gpioexti_pkg::PORT_W'($urandom_range(8));
      c.family_s         = 1'($urandom_range(1));
      c.exti_conf_one    = 8'($urandom);
      c.exti_conf_two    = 8'($urandom);
      c.sense_word_one   = 8'($urandom);
      c.sense_word_two   = 8'($urandom);
      c.sense_word_three = 8'($urandom);
      c.sense_word_four  = 8'($urandom);
      return c;
   endfunction

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // control one comes out of reset nonzero, everything else cleared
   task automatic test_reset_state();
      send_item(gpioexti_pkg::ACT_RECHECK, 8'hFF);
   endtask

   // every register write, most at both extremes, plus mixed direction and status writes
   task automatic test_register_access();
      send_item(gpioexti_pkg::ACT_OUT_DATA, 8'hFF);
      send_item(gpioexti_pkg::ACT_DIRECTION, 8'hFF);   // all outputs, level reads back out data
      send_item(gpioexti_pkg::ACT_CTRL_ONE, 8'h00);
      send_item(gpioexti_pkg::ACT_CTRL_TWO, 8'hFF);    // enabled but all outputs: no detection
      send_item(gpioexti_pkg::ACT_STAT_ONE, 8'hFF);
      send_item(gpioexti_pkg::ACT_STAT_TWO, 8'hFF);
      send_item(gpioexti_pkg::ACT_STAT_TWO, 8'h00);
      send_item(gpioexti_pkg::ACT_DIRECTION, 8'h3C);   // mixed level kept as the pin state
      send_item(gpioexti_pkg::ACT_PIN_DRIVE, 8'h00);
      send_item(gpioexti_pkg::ACT_DIRECTION, 8'h00);
      send_item(gpioexti_pkg::ACT_STAT_ONE, 8'h00);    // low level sets the bits right back
      send_item(gpioexti_pkg::ACT_PIN_DRIVE, 8'hFF);
      send_item(gpioexti_pkg::ACT_CTRL_ONE, 8'hFF);
   endtask

   // one pin per sensitivity code in each nibble, other family port A
   task automatic test_pin_sensitivity();
      gpioexti_pkg::cfg_type c;
      c = port_cfg;
      c.sense_word_one = {gpioexti_pkg::SENSE_BOTH, gpioexti_pkg::SENSE_FALLING,
                          gpioexti_pkg::SENSE_RISING, gpioexti_pkg::SENSE_LOW};
      c.sense_word_two = {gpioexti_pkg::SENSE_LOW, gpioexti_pkg::SENSE_RISING,
                          gpioexti_pkg::SENSE_FALLING, gpioexti_pkg::SENSE_BOTH};
      drain_port();
      program_port(c);
      send_item(gpioexti_pkg::ACT_STAT_ONE, 8'h00);
      send_item(gpioexti_pkg::ACT_PIN_DRIVE, 8'h00);
      send_item(gpioexti_pkg::ACT_STAT_ONE, 8'h00);
      send_item(gpioexti_pkg::ACT_PIN_DRIVE, 8'hFF);
      send_item(gpioexti_pkg::ACT_RECHECK, 8'h5A);
   endtask

   // whole-port flags: s family port C, a port past I, other family port E
   task automatic test_port_flags();
      gpioexti_pkg::cfg_type c;
      c = '0;
      c.family_s = 1'b1;
      c.port_index = gpioexti_pkg::PORT_C;
      c.sense_word_one = {2'b00, gpioexti_pkg::SENSE_RISING, 4'b0000};
      drain_port();
      program_port(c);
      send_item(gpioexti_pkg::ACT_PIN_DRIVE, 8'h00);
      send_item(gpioexti_pkg::ACT_PIN_DRIVE, 8'h01);
      c.family_s = 1'b0;
      c.port_index = 4'd12;
      drain_port();
      program_port(c);
      send_item(gpioexti_pkg::ACT_PIN_DRIVE, 8'h00);
      c.port_index = gpioexti_pkg::PORT_E;
      c.exti_conf_one = 8'h30;
      c.sense_word_three = {2'b00, gpioexti_pkg::SENSE_BOTH, 4'b0000};
      drain_port();
      program_port(c);
      send_item(gpioexti_pkg::ACT_PIN_DRIVE, 8'h80);
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45)
         send_item(gpioexti_pkg::ACT_PIN_DRIVE, 8'($urandom));
      else if (pick < 55)
         send_item(gpioexti_pkg::ACT_RECHECK, 8'($urandom));
      else if (pick < 63)
         send_item(gpioexti_pkg::ACT_DIRECTION, $urandom_range(1) ? 8'h00 : 8'($urandom));
      else if (pick < 70)
         send_item(gpioexti_pkg::ACT_OUT_DATA, 8'($urandom));
      else if (pick < 74)
         send_item(gpioexti_pkg::ACT_CTRL_ONE, 8'($urandom));
      else if (pick < 82)
         send_item(gpioexti_pkg::ACT_CTRL_TWO, $urandom_range(1) ? 8'hFF : 8'($urandom));
      // status mostly cleared so new detections keep showing as changes
      else if (pick < 91)
         send_item(gpioexti_pkg::ACT_STAT_ONE,
                   ($urandom_range(9) < 6) ? 8'h00 : 8'($urandom));
      else
         send_item(gpioexti_pkg::ACT_STAT_TWO,
                   ($urandom_range(9) < 6) ? 8'h00 : 8'($urandom));
   endtask

   // four idling phases, six csr settings each, extremes among them
   task automatic test_random_traffic();
      gpioexti_pkg::cfg_type c;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1:       begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
            default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
         endcase
         for (int seg = 0; seg < 6; seg++) begin
            c = random_setting();
            if (phase == 0 && seg == 0) c = '0;
            if (phase == 0 && seg == 1) c = '1;
            if (phase == 1 && seg == 0) begin
               c = '1;
               c.port_index = gpioexti_pkg::PORT_I;
               c.family_s = 1'b0;
            end
            drain_port();
            program_port(c);
            for (int n = 0; n < 56; n++) begin
               // occasional full stop mid-stream
               if ($urandom_range(199) == 0) drain_port();
               random_item();
            end
         end
      end
   endtask

   initial begin
      mismatch_count = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      reset_model();
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.action <= gpioexti_pkg::ACT_RECHECK;
      req_bus.value  <= '0;
      csr_bus.valid  <= 1'b0;
      csr_bus.index  <= gpioexti_pkg::CSR_PORT_INDEX;
      csr_bus.data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_register_access();
      test_pin_sensitivity();
      test_port_flags();
      test_random_traffic();

      drain_port();
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
